// ===== design/sdx_pkg.sv =====
`default_nettype none

package sdx_pkg;

    localparam int CODE_LENGTH_DEF = 4;
    localparam int DIGIT_STORE     = 7;
    localparam int OUT_DIGITS      = 3;
    localparam int CODE_W          = 3;
    localparam int CHAR_W          = 8;
    localparam int DIGIT_W         = 6;
    localparam int TDATA_W         = 32;

    localparam logic [DIGIT_W-1:0] PAD_CHAR = 6'd48;
    localparam logic [CODE_W-1:0]  CODE_NONE = 3'd0;

    typedef logic [CODE_W-1:0] code_t;
    typedef logic [CHAR_W-1:0] char_t;

    function automatic char_t to_upper(input char_t c);
        char_t r;
        r = c;
        if (c inside {[8'd97:8'd122]}) begin
            r = c - 8'd32;
        end
        return r;
    endfunction

    function automatic code_t letter_code(input char_t c);
        code_t r;
        case (c)
            "B", "F", "P", "V":                r = 3'd1;
            "C", "G", "J", "K", "Q", "S", "Z": r = 3'd2;
            "D", "T":                          r = 3'd3;
            "L":                               r = 3'd4;
            "M", "N":                          r = 3'd5;
            "R":                               r = 3'd6;
            default:                           r = CODE_NONE;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/soundex_word_encoder.sv =====
// soundex_word_encoder: phonetic code of a word streamed one character a transfer
//
// input channel: s_tdata carries one ASCII byte, s_tlast marks the last byte of
// the word. the first byte is kept upper-cased as the lead letter, later letters
// are mapped to codes 1..6 and merged into up to three digits.
// result channel: one transfer per word, issued for the byte that has s_tlast set;
// m_tdata holds the lead letter and three ASCII digits, '0' where no code was held.
// latency: the result is valid in the cycle after the last byte is taken.
// throughput: one byte per cycle while s_tready is high; the per-byte update is a
// combinational table lookup and compare feeding the word state registers.
// the result sits in an output register; while it waits with m_tready low,
// s_tready is low and the input stalls until m_tready frees it.
// reset (aresetn low, synchronous) drops any result held and starts a new word.
// CODE_LENGTH sets how many digits a word collects (CODE_LENGTH-1, at most seven);
// only the first three are shown, missing ones read as '0'.
`default_nettype none

module soundex_word_encoder #(
    parameter int CODE_LENGTH = sdx_pkg::CODE_LENGTH_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // s_tdata: [7:0] character
    input  wire logic [sdx_pkg::CHAR_W-1:0]  s_tdata,
    input  wire logic                        s_tlast,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // m_tdata: [7:0] lead_letter, [13:8] first_digit, [19:14] second_digit,
    // [25:20] third_digit, [31:26] zero
    output logic [sdx_pkg::TDATA_W-1:0]      m_tdata,
    output logic                             m_tvalid,
    input  wire logic                        m_tready
);

    localparam int DIGIT_LIMIT = (CODE_LENGTH - 1 > sdx_pkg::DIGIT_STORE) ?
                                 sdx_pkg::DIGIT_STORE : CODE_LENGTH - 1;
    localparam int CNT_W = (DIGIT_LIMIT < 2) ? 1 : $clog2(DIGIT_LIMIT + 1);
    localparam int NDIG  = sdx_pkg::OUT_DIGITS;

    // word state
    sdx_pkg::char_t                 lead_reg, lead_next;
    logic                           seen_reg;
    logic [CNT_W-1:0]               count_reg, count_next;
    sdx_pkg::code_t                 prev_reg, prev_next;
    sdx_pkg::code_t                 digits_reg [NDIG];
    sdx_pkg::code_t                 digits_next [NDIG];

    // result register
    logic                           out_valid_reg;
    logic [sdx_pkg::TDATA_W-1:0]    out_data_reg, out_data_next;

    sdx_pkg::char_t                 ch_up;
    sdx_pkg::code_t                 code;
    logic                           append;
    logic                           accept;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign ch_up = sdx_pkg::to_upper(s_tdata);
    assign code  = sdx_pkg::letter_code(ch_up);

    // first coded letter after the lead goes in below the digit limit, later ones only on a change of code
    assign append = seen_reg && (code != sdx_pkg::CODE_NONE) &&
                    (count_reg < CNT_W'(DIGIT_LIMIT)) &&
                    ((count_reg == '0) || (code != prev_reg));

    always_comb begin
        lead_next  = seen_reg ? lead_reg : ch_up;
        count_next = append ? count_reg + CNT_W'(1) : count_reg;
        prev_next  = append ? code : prev_reg;
        for (int k = 0; k < NDIG; k++) begin
            digits_next[k] = digits_reg[k];
            if (k < DIGIT_LIMIT) begin
                if (append && (count_reg == CNT_W'(k))) begin
                    digits_next[k] = code;
                end
            end
        end
        out_data_next = '0;
        out_data_next[sdx_pkg::CHAR_W-1:0] = lead_next;
        for (int k = 0; k < NDIG; k++) begin
            out_data_next[sdx_pkg::CHAR_W + k*sdx_pkg::DIGIT_W +: sdx_pkg::DIGIT_W] =
                sdx_pkg::PAD_CHAR +
                {{(sdx_pkg::DIGIT_W-sdx_pkg::CODE_W){1'b0}}, digits_next[k]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lead_reg  <= '0;
            seen_reg  <= 1'b0;
            count_reg <= '0;
            prev_reg  <= sdx_pkg::CODE_NONE;
            for (int k = 0; k < NDIG; k++) begin
                digits_reg[k] <= sdx_pkg::CODE_NONE;
            end
        end else if (accept) begin
            if (s_tlast) begin
                // word done, start over
                lead_reg  <= '0;
                seen_reg  <= 1'b0;
                count_reg <= '0;
                prev_reg  <= sdx_pkg::CODE_NONE;
                for (int k = 0; k < NDIG; k++) begin
                    digits_reg[k] <= sdx_pkg::CODE_NONE;
                end
            end else begin
                lead_reg  <= lead_next;
                seen_reg  <= 1'b1;
                count_reg <= count_next;
                prev_reg  <= prev_next;
                for (int k = 0; k < NDIG; k++) begin
                    digits_reg[k] <= digits_next[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept && s_tlast) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_tlast) begin
            out_data_reg <= out_data_next;
        end
    end

    a_count_limit : assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DIGIT_LIMIT))
        else $error("digit count beyond limit");

    a_word_restart : assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_tlast |=> !seen_reg && (count_reg == '0) && m_tvalid)
        else $error("word end did not restart state and raise result");

    a_digits_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[13:8] <= 6'd54) && (m_tdata[19:14] <= 6'd54) &&
                     (m_tdata[25:20] <= 6'd54) && (m_tdata[13:8] >= 6'd48))
        else $error("result digit out of range");

    a_empty_digit : assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (digits_reg[0] == sdx_pkg::CODE_NONE) &&
                              (prev_reg == sdx_pkg::CODE_NONE))
        else $error("digit held with zero count");

    a_code_before_lead : assert property (@(posedge aclk) disable iff (!aresetn)
        !seen_reg |-> (count_reg == '0))
        else $error("digits collected before lead letter");

endmodule

`default_nettype wire
